/* hdl/lprt_pkg.sv */
// Shared types and constants for the linear-probe rule table.
package lprt_pkg;

  localparam int DEFAULT_DEPTH = 256;
  localparam int KEY_W = 32;
  localparam int RULE_W = 32;
  localparam int FOLD_W = 8;
  localparam int STATUS_W = 3;
  localparam int MODE_W = 2;

  localparam logic [KEY_W-1:0] SUBST_RESET = 32'd1;

  localparam int FOLD_ROUNDS = 32;
  localparam int ROUNDS_PER_STEP = 4;
  localparam int FOLD_STEPS = FOLD_ROUNDS / ROUNDS_PER_STEP;
  localparam int FOLD_CNT_W = $clog2(FOLD_STEPS);
  localparam int MOD_STEPS = FOLD_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);
  localparam int MOD_CMP_W = 16;
  localparam int HASH_LIMIT = 1 << FOLD_W;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GET = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EXISTS = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DUP = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_MISSING = 3'd4;

  typedef enum logic [1:0] {
    H_IDLE,
    H_FOLD,
    H_MOD,
    H_DONE
  } hash_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CMP,
    S_WRITE
  } ctl_state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } store_ctl_t;

endpackage

/* hdl/lprt_hash.sv */
// Iterative home-slot unit: byte fold of the key, then reduction modulo the depth.
module lprt_hash #(
  parameter int TABLE_DEPTH = lprt_pkg::DEFAULT_DEPTH,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [lprt_pkg::KEY_W-1:0]   key_i,
  output logic                         done_o,
  output logic [AW-1:0]                slot_o
);

  localparam bit NEED_MOD = TABLE_DEPTH < lprt_pkg::HASH_LIMIT;
  localparam logic [lprt_pkg::MOD_CMP_W-1:0] DEP_W = lprt_pkg::MOD_CMP_W'(TABLE_DEPTH);

  lprt_pkg::hash_state_t state_r, state_nxt;
  logic [lprt_pkg::KEY_W-1:0]      k_r, k_nxt;
  logic [lprt_pkg::FOLD_W-1:0]     sum_r, sum_nxt;
  logic [lprt_pkg::FOLD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lprt_pkg::MOD_CNT_W-1:0]  step_r, step_nxt;
  logic [lprt_pkg::KEY_W-1:0]      k_fold;
  logic [lprt_pkg::FOLD_W-1:0]     s_fold;
  logic [lprt_pkg::MOD_CMP_W-1:0]  sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lprt_pkg::H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    step_r <= step_nxt;
  end

  always_comb begin
    logic [lprt_pkg::KEY_W-1:0]  kk;
    logic [lprt_pkg::FOLD_W-1:0] ss;
    kk = k_r;
    ss = sum_r;
    for (int j = 0; j < lprt_pkg::ROUNDS_PER_STEP; j++) begin
      ss = ss ^ kk[lprt_pkg::FOLD_W-1:0];
      kk = kk >> 1;
    end
    k_fold = kk;
    s_fold = ss;
  end

  assign sh = DEP_W << step_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    done_o    = 1'b0;
    unique case (state_r)
      lprt_pkg::H_IDLE: begin
        if (start_i) begin
          k_nxt     = key_i;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = lprt_pkg::H_FOLD;
        end
      end
      lprt_pkg::H_FOLD: begin
        k_nxt   = k_fold;
        sum_nxt = s_fold;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == lprt_pkg::FOLD_CNT_W'(lprt_pkg::FOLD_STEPS - 1)) begin
          step_nxt  = lprt_pkg::MOD_CNT_W'(lprt_pkg::MOD_STEPS - 1);
          state_nxt = NEED_MOD ? lprt_pkg::H_MOD : lprt_pkg::H_DONE;
        end
      end
      lprt_pkg::H_MOD: begin
        if ({{(lprt_pkg::MOD_CMP_W - lprt_pkg::FOLD_W){1'b0}}, sum_r} >= sh) begin
          sum_nxt = sum_r - sh[lprt_pkg::FOLD_W-1:0];
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = lprt_pkg::H_DONE;
        end
      end
      lprt_pkg::H_DONE: begin
        done_o    = 1'b1;
        state_nxt = lprt_pkg::H_IDLE;
      end
      default: begin
        state_nxt = lprt_pkg::H_IDLE;
      end
    endcase
  end

  assign slot_o = AW'(sum_r);

endmodule

/* hdl/lprt_store.sv */
// Slot memories: occupancy with key, and rule word, one port each with registered read.
module lprt_store #(
  parameter int TABLE_DEPTH = lprt_pkg::DEFAULT_DEPTH,
  parameter int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                        clk,
  input  lprt_pkg::store_ctl_t        ctl_i,
  input  logic [AW-1:0]               addr_i,
  input  logic                        wr_used_i,
  input  logic [lprt_pkg::KEY_W-1:0]  wr_key_i,
  input  logic [lprt_pkg::RULE_W-1:0] wr_rule_i,
  output logic                        rd_used_o,
  output logic [lprt_pkg::KEY_W-1:0]  rd_key_o,
  output logic [lprt_pkg::RULE_W-1:0] rd_rule_o
);

  logic [lprt_pkg::KEY_W:0]    key_mem [TABLE_DEPTH];
  logic [lprt_pkg::RULE_W-1:0] rule_mem [TABLE_DEPTH];
  logic [lprt_pkg::KEY_W:0]    key_q_r;
  logic [lprt_pkg::RULE_W-1:0] rule_q_r;

  always_ff @(posedge clk) begin
    if (ctl_i.wr) begin
      key_mem[addr_i] <= {wr_used_i, wr_key_i};
    end
    if (ctl_i.rd) begin
      key_q_r <= key_mem[addr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.wr) begin
      rule_mem[addr_i] <= wr_rule_i;
    end
    if (ctl_i.rd) begin
      rule_q_r <= rule_mem[addr_i];
    end
  end

  assign rd_used_o = key_q_r[lprt_pkg::KEY_W];
  assign rd_key_o  = key_q_r[lprt_pkg::KEY_W-1:0];
  assign rd_rule_o = rule_q_r;

endmodule

/* hdl/linear_probe_rule_table_top.sv */
// Linear-probe rule table: sequencer, substitute-key register and unit instances.
//
// After reset the block sweeps the key memory to mark every slot empty, one slot per
// cycle, so busy stays high through the whole sweep before the first beat is taken;
// configuration writes are taken during that sweep. An operation is taken when start is
// high and busy is low, and its result appears on the out_ ports for one cycle with
// out_strobe high; the receiver cannot hold it off. An operation runs the byte fold
// (four rounds a cycle), then the modulo reduction when TABLE_DEPTH is below 256, then
// P probes of the single-port key memory, each a read and then a compare, where P
// runs from 1 up to TABLE_DEPTH; the result is then registered. The next operation may
// start in the cycle that shows the result.
module linear_probe_rule_table_top #(
  parameter int TABLE_DEPTH = lprt_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [lprt_pkg::MODE_W-1:0]   in_mode,
  input  logic [lprt_pkg::KEY_W-1:0]    in_lookup_key,
  input  logic [lprt_pkg::RULE_W-1:0]   in_rule_value,
  output logic                          out_strobe,
  output logic [lprt_pkg::STATUS_W-1:0] out_status,
  output logic                          out_found,
  output logic [lprt_pkg::RULE_W-1:0]   out_rule_out,
  input  logic                          cfg_wr_en,
  input  logic [lprt_pkg::KEY_W-1:0]    cfg_wr_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] LAST_PROBE = CW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  lprt_pkg::ctl_state_t state_r, state_nxt;
  logic [lprt_pkg::KEY_W-1:0]    subst_r;
  logic [lprt_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [lprt_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [lprt_pkg::RULE_W-1:0]   rule_r, rule_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic [CW-1:0]                 probe_r, probe_nxt;
  logic [CW-1:0]                 entry_r, entry_nxt;
  logic                          found_r, found_nxt;
  logic                          strobe_r, strobe_nxt;
  logic [lprt_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                          ofound_r, ofound_nxt;
  logic [lprt_pkg::RULE_W-1:0]   orule_r, orule_nxt;

  logic [lprt_pkg::KEY_W-1:0]    key_in;
  logic                          hash_start;
  logic                          hash_done;
  logic [AW-1:0]                 hash_slot;
  logic [AW-1:0]                 idx_inc;
  lprt_pkg::store_ctl_t          st_ctl;
  logic                          st_used;
  logic [lprt_pkg::KEY_W-1:0]    st_key;
  logic [lprt_pkg::RULE_W-1:0]   st_rule;
  logic                          rd_used;
  logic [lprt_pkg::KEY_W-1:0]    rd_key;
  logic [lprt_pkg::RULE_W-1:0]   rd_rule;

  lprt_hash #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (hash_start),
    .key_i   (key_in),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  lprt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk       (clk),
    .ctl_i     (st_ctl),
    .addr_i    (idx_r),
    .wr_used_i (st_used),
    .wr_key_i  (st_key),
    .wr_rule_i (st_rule),
    .rd_used_o (rd_used),
    .rd_key_o  (rd_key),
    .rd_rule_o (rd_rule)
  );

  assign key_in  = (in_lookup_key == '0) ? subst_r : in_lookup_key;
  assign idx_inc = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lprt_pkg::S_CLEAR;
      subst_r  <= lprt_pkg::SUBST_RESET;
      idx_r    <= '0;
      entry_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      entry_r  <= entry_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_wr_en) begin
        subst_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    rule_r   <= rule_nxt;
    probe_r  <= probe_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    ofound_r <= ofound_nxt;
    orule_r  <= orule_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    rule_nxt   = rule_r;
    idx_nxt    = idx_r;
    probe_nxt  = probe_r;
    entry_nxt  = entry_r;
    found_nxt  = found_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    ofound_nxt = ofound_r;
    orule_nxt  = orule_r;
    hash_start = 1'b0;
    st_ctl     = '0;
    st_used    = 1'b0;
    st_key     = '0;
    st_rule    = '0;
    unique case (state_r)
      lprt_pkg::S_CLEAR: begin
        st_ctl.wr = 1'b1;
        idx_nxt   = idx_inc;
        if (idx_r == LAST_SLOT) begin
          state_nxt = lprt_pkg::S_IDLE;
        end
      end
      lprt_pkg::S_IDLE: begin
        if (start) begin
          mode_nxt   = in_mode;
          key_nxt    = key_in;
          rule_nxt   = in_rule_value;
          hash_start = 1'b1;
          state_nxt  = lprt_pkg::S_HASH;
        end
      end
      lprt_pkg::S_HASH: begin
        if (hash_done) begin
          idx_nxt   = hash_slot;
          probe_nxt = '0;
          state_nxt = lprt_pkg::S_READ;
        end
      end
      lprt_pkg::S_READ: begin
        st_ctl.rd = 1'b1;
        state_nxt = lprt_pkg::S_CMP;
      end
      lprt_pkg::S_CMP: begin
        if (!rd_used) begin
          found_nxt = 1'b0;
          state_nxt = lprt_pkg::S_WRITE;
        end else if (rd_key == key_r) begin
          found_nxt = 1'b1;
          state_nxt = lprt_pkg::S_WRITE;
        end else if (probe_r == LAST_PROBE) begin
          found_nxt = 1'b0;
          state_nxt = lprt_pkg::S_WRITE;
        end else begin
          probe_nxt = probe_r + 1'b1;
          idx_nxt   = idx_inc;
          state_nxt = lprt_pkg::S_READ;
        end
      end
      lprt_pkg::S_WRITE: begin
        strobe_nxt = 1'b1;
        ofound_nxt = found_r;
        status_nxt = lprt_pkg::STAT_OK;
        orule_nxt  = '0;
        state_nxt  = lprt_pkg::S_IDLE;
        unique case (mode_r) inside
          lprt_pkg::MODE_ADD: begin
            if (entry_r == FULL_COUNT) begin
              status_nxt = lprt_pkg::STAT_FULL;
            end else if (found_r) begin
              status_nxt = lprt_pkg::STAT_DUP;
            end else begin
              st_ctl.wr = 1'b1;
              st_used   = 1'b1;
              st_key    = key_r;
              st_rule   = rule_r;
              entry_nxt = entry_r + 1'b1;
            end
          end
          lprt_pkg::MODE_DEL, lprt_pkg::MODE_GET: begin
            if (entry_r == '0) begin
              status_nxt = lprt_pkg::STAT_EMPTY;
            end else if (!found_r) begin
              status_nxt = lprt_pkg::STAT_MISSING;
            end else if (mode_r == lprt_pkg::MODE_DEL) begin
              st_ctl.wr = 1'b1;
              entry_nxt = entry_r - 1'b1;
            end else begin
              orule_nxt = rd_rule;
            end
          end
          lprt_pkg::MODE_EXISTS: begin
            status_nxt = lprt_pkg::STAT_OK;
          end
          default: begin
            status_nxt = lprt_pkg::STAT_OK;
          end
        endcase
      end
      default: begin
        state_nxt = lprt_pkg::S_IDLE;
      end
    endcase
  end

  assign busy         = (state_r != lprt_pkg::S_IDLE);
  assign out_strobe   = strobe_r;
  assign out_status   = status_r;
  assign out_found    = ofound_r;
  assign out_rule_out = orule_r;

endmodule

/* hdl/lprt_checker.sv */
// Port-level checks on the rule table's handshake and results, bound to the top level.
module lprt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [lprt_pkg::STATUS_W-1:0] out_status,
  input logic                          out_found,
  input logic [lprt_pkg::RULE_W-1:0]   out_rule_out
);

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy) && !busy)
    else $error("result beat without an operation in flight");

  a_rule_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != lprt_pkg::STAT_OK |-> out_rule_out == '0)
    else $error("rule word driven on a failed operation");

  a_dup_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == lprt_pkg::STAT_DUP || out_status == lprt_pkg::STAT_MISSING)
      |-> out_found == (out_status == lprt_pkg::STAT_DUP))
    else $error("found flag disagrees with status");

endmodule

bind linear_probe_rule_table_top lprt_checker u_lprt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_status   (out_status),
  .out_found    (out_found),
  .out_rule_out (out_rule_out)
);

/* tb/sv/linear_probe_rule_table_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the linear-probe rule table: directed, random and fill tests.
module linear_probe_rule_table_top_test;

  localparam int DEPTH = lprt_pkg::DEFAULT_DEPTH;
  localparam int RANDOM_ITEMS = 210;
  localparam int PHASE_ITEMS = 70;
  localparam int POOL_SIZE = 24;
  localparam int STALL_LIMIT = 4000;
  localparam int END_WAIT = 600;

  typedef struct {
    logic [lprt_pkg::STATUS_W-1:0] status;
    logic                          found;
    logic [lprt_pkg::RULE_W-1:0]   rule;
  } table_reply_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [lprt_pkg::MODE_W-1:0]   in_mode;
  logic [lprt_pkg::KEY_W-1:0]    in_lookup_key;
  logic [lprt_pkg::RULE_W-1:0]   in_rule_value;
  logic                          out_strobe;
  logic [lprt_pkg::STATUS_W-1:0] out_status;
  logic                          out_found;
  logic [lprt_pkg::RULE_W-1:0]   out_rule_out;
  logic                          cfg_wr_en;
  logic [lprt_pkg::KEY_W-1:0]    cfg_wr_data;

  logic [lprt_pkg::KEY_W-1:0]  slot_key [DEPTH];
  logic [lprt_pkg::RULE_W-1:0] slot_rule [DEPTH];
  bit                          slot_used [DEPTH];
  int unsigned                 entry_total;
  logic [lprt_pkg::KEY_W-1:0]  zero_subst;

  table_reply_t table_replies [$];
  int error_count = 0;
  int stall_cycles = 0;
  bit gaps_on = 1'b1;

  linear_probe_rule_table_top #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_lookup_key(in_lookup_key),
    .in_rule_value(in_rule_value),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_rule_out (out_rule_out),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned home_of(input logic [lprt_pkg::KEY_W-1:0] key);
    logic [lprt_pkg::FOLD_W-1:0] acc;
    logic [lprt_pkg::KEY_W-1:0]  k;
    acc = '0;
    k = key;
    for (int r = 0; r < lprt_pkg::FOLD_ROUNDS; r++) begin
      acc ^= k[lprt_pkg::FOLD_W-1:0];
      k = k >> 1;
    end
    return int'(acc) % DEPTH;
  endfunction

  function automatic bit locate(input logic [lprt_pkg::KEY_W-1:0] key,
                                output int unsigned slot);
    int unsigned idx;
    idx = home_of(key);
    slot = 0;
    for (int n = 0; n < DEPTH; n++) begin
      if (!slot_used[idx]) return 1'b0;
      if (slot_key[idx] == key) begin
        slot = idx;
        return 1'b1;
      end
      idx = (idx + 1) % DEPTH;
    end
    return 1'b0;
  endfunction

  function automatic table_reply_t run_table_op(input logic [lprt_pkg::MODE_W-1:0] mode,
                                                input logic [lprt_pkg::KEY_W-1:0] key_in,
                                                input logic [lprt_pkg::RULE_W-1:0] rule_in);
    table_reply_t               res;
    logic [lprt_pkg::KEY_W-1:0] key;
    int unsigned                slot;
    int unsigned                idx;
    bit                         hit;
    res.status = lprt_pkg::STAT_OK;
    res.rule = '0;
    key = (key_in == '0) ? zero_subst : key_in;
    hit = locate(key, slot);
    res.found = hit;
    case (mode) inside
      lprt_pkg::MODE_ADD: begin
        if (entry_total >= DEPTH) begin
          res.status = lprt_pkg::STAT_FULL;
        end else if (hit) begin
          res.status = lprt_pkg::STAT_DUP;
        end else begin
          idx = home_of(key);
          while (slot_used[idx]) idx = (idx + 1) % DEPTH;
          slot_used[idx] = 1'b1;
          slot_key[idx] = key;
          slot_rule[idx] = rule_in;
          entry_total++;
        end
      end
      lprt_pkg::MODE_DEL, lprt_pkg::MODE_GET: begin
        if (entry_total == 0) begin
          res.status = lprt_pkg::STAT_EMPTY;
        end else if (!hit) begin
          res.status = lprt_pkg::STAT_MISSING;
        end else if (mode == lprt_pkg::MODE_DEL) begin
          slot_used[slot] = 1'b0;
          slot_key[slot] = '0;
          slot_rule[slot] = '0;
          entry_total--;
        end else begin
          res.rule = slot_rule[slot];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [lprt_pkg::KEY_W-1:0] key_for_slot(input int unsigned slot);
    logic [lprt_pkg::KEY_W-1:0] k;
    do k = $urandom(); while (k == '0 || home_of(k) != slot);
    return k;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic send_op(input logic [lprt_pkg::MODE_W-1:0] mode,
                         input logic [lprt_pkg::KEY_W-1:0] key,
                         input logic [lprt_pkg::RULE_W-1:0] rule);
    if (gaps_on && $urandom_range(99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_lookup_key <= key;
    in_rule_value <= rule;
    do @(posedge clk); while (busy !== 1'b0);
    table_replies.push_back(run_table_op(mode, key, rule));
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    do @(posedge clk); while (table_replies.size() != 0);
  endtask

  task automatic write_subst(input logic [lprt_pkg::KEY_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    zero_subst = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_op(lprt_pkg::MODE_GET, 32'hFFFF_FFFF, '0);
    send_op(lprt_pkg::MODE_DEL, '0, 32'hFFFF_FFFF);
    send_op(lprt_pkg::MODE_EXISTS, $urandom(), $urandom());
  endtask

  task automatic test_basic_ops();
    send_op(lprt_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(lprt_pkg::MODE_ADD, '0, '0);
    send_op(lprt_pkg::MODE_ADD, 32'hFFFF_FFFF, $urandom());
    send_op(lprt_pkg::MODE_GET, 32'hFFFF_FFFF, '0);
    send_op(lprt_pkg::MODE_GET, '0, $urandom());
    send_op(lprt_pkg::MODE_EXISTS, 32'd1, '0);
    send_op(lprt_pkg::MODE_DEL, 32'hFFFF_FFFF, '0);
    send_op(lprt_pkg::MODE_GET, 32'hFFFF_FFFF, '0);
    send_op(lprt_pkg::MODE_DEL, 32'hFFFF_FFFF, '0);
  endtask

  task automatic test_zero_substitute();
    drain_replies();
    write_subst(32'hFFFF_FFFF);
    send_op(lprt_pkg::MODE_ADD, '0, $urandom());
    send_op(lprt_pkg::MODE_GET, 32'hFFFF_FFFF, '0);
    drain_replies();
    write_subst('0);
    send_op(lprt_pkg::MODE_ADD, '0, $urandom());
    send_op(lprt_pkg::MODE_GET, '0, '0);
    send_op(lprt_pkg::MODE_EXISTS, '0, '0);
    drain_replies();
    write_subst(lprt_pkg::SUBST_RESET);
    send_op(lprt_pkg::MODE_GET, '0, '0);
  endtask

  task automatic test_probe_runs();
    logic [lprt_pkg::KEY_W-1:0] run_key [3];
    logic [lprt_pkg::KEY_W-1:0] wrap_key [2];
    for (int i = 0; i < 3; i++) run_key[i] = key_for_slot(7);
    for (int i = 0; i < 2; i++) wrap_key[i] = key_for_slot(DEPTH - 1);
    for (int i = 0; i < 3; i++) send_op(lprt_pkg::MODE_ADD, run_key[i], $urandom());
    send_op(lprt_pkg::MODE_DEL, run_key[0], '0);
    send_op(lprt_pkg::MODE_GET, run_key[1], '0);
    send_op(lprt_pkg::MODE_ADD, run_key[1], $urandom());
    send_op(lprt_pkg::MODE_ADD, wrap_key[0], $urandom());
    send_op(lprt_pkg::MODE_ADD, wrap_key[1], $urandom());
    send_op(lprt_pkg::MODE_GET, wrap_key[1], '0);
  endtask

  task automatic test_random_traffic();
    logic [lprt_pkg::KEY_W-1:0]  pool [POOL_SIZE];
    logic [lprt_pkg::KEY_W-1:0]  key;
    logic [lprt_pkg::MODE_W-1:0] mode;
    int unsigned                 pick;
    int unsigned                 phase;
    for (int i = 0; i < POOL_SIZE; i++)
      pool[i] = (i < POOL_SIZE / 2) ? $urandom() : key_for_slot(40 + (i % 3) * 90);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        phase = n / PHASE_ITEMS;
        drain_replies();
        case (phase)
          0: write_subst(pool[$urandom_range(POOL_SIZE - 1)]);
          1: write_subst(32'hFFFF_FFFF);
          default: write_subst($urandom_range(32'hFFFF_FFFF, 1));
        endcase
        gaps_on = (phase != 1);
      end
      pick = $urandom_range(99);
      if (pick < 40) mode = lprt_pkg::MODE_ADD;
      else if (pick < 60) mode = lprt_pkg::MODE_DEL;
      else if (pick < 80) mode = lprt_pkg::MODE_GET;
      else mode = lprt_pkg::MODE_EXISTS;
      pick = $urandom_range(99);
      if (pick < 55) key = pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 65) key = '0;
      else key = $urandom();
      send_op(mode, key, $urandom());
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_full_table();
    logic [lprt_pkg::KEY_W-1:0] kept_key;
    while (entry_total < DEPTH) send_op(lprt_pkg::MODE_ADD, $urandom(), $urandom());
    kept_key = slot_key[$urandom_range(DEPTH - 1)];
    send_op(lprt_pkg::MODE_ADD, $urandom(), $urandom());
    send_op(lprt_pkg::MODE_ADD, kept_key, $urandom());
    send_op(lprt_pkg::MODE_GET, kept_key, '0);
    send_op(lprt_pkg::MODE_EXISTS, $urandom(), '0);
    send_op(lprt_pkg::MODE_DEL, kept_key, '0);
    send_op(lprt_pkg::MODE_ADD, kept_key, $urandom());
  endtask

  always @(posedge clk) begin : check_reply
    table_reply_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (table_replies.size() == 0) begin
        report_mismatch("unexpected result beat", out_status, '0);
      end else begin
        want = table_replies.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_found !== want.found) report_mismatch("found", out_found, want.found);
        if (out_rule_out !== want.rule) report_mismatch("rule_out", out_rule_out, want.rule);
      end
    end
  end

  always @(posedge clk) begin
    if ((rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= lprt_pkg::MODE_EXISTS;
    in_lookup_key <= '0;
    in_rule_value <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    zero_subst = lprt_pkg::SUBST_RESET;
    entry_total = 0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_rule[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_basic_ops();
    test_zero_substitute();
    test_probe_runs();
    test_random_traffic();
    test_full_table();
    drain_replies();
    repeat (END_WAIT) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/lprt_pkg.sv
hdl/lprt_hash.sv
hdl/lprt_store.sv
hdl/linear_probe_rule_table_top.sv
hdl/lprt_checker.sv
tb/sv/linear_probe_rule_table_top_test.sv
